### rtl/color_palette_class_table_core_defines.svh
// assertion macros for the palette class table
`ifndef COLOR_PALETTE_CLASS_TABLE_CORE_DEFINES_SVH
`define COLOR_PALETTE_CLASS_TABLE_CORE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define CPCT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cpct assertion failed");
// next-cycle implication
`define CPCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cpct assertion failed");
`else
`define CPCT_ASSERT_NOW(lbl, ante, cons)
`define CPCT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/cpct_pkg.sv
package cpct_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int IDX_W         = $clog2(PALETTE_DEPTH);
  localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
  localparam int COLOR_W       = 24;
  localparam int VAL_W         = 16;
  localparam int CMP_W         = VAL_W + 1;
  localparam logic [7:0] HALF_Q8 = 8'd128;

  typedef enum logic {
    ACT_CLASSIFY = 1'b0,
    ACT_RENDER   = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RD,
    ST_RDATA,
    ST_FINISH
  } state_e;

  // result flags, packed in the order of the output tuser
  typedef struct packed {
    logic empty;
    logic full;
    logic fresh;
  } flags_t;

endpackage

### rtl/cpct_ram.sv
module cpct_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/cpct_idx.sv
// clamp and round a signed q8.8 class value into the stored index range
module cpct_idx (
  input  logic signed [cpct_pkg::VAL_W-1:0] class_value_i,
  input  logic        [cpct_pkg::CNT_W-1:0] count_i,
  output logic        [cpct_pkg::IDX_W-1:0] idx_o
);

  logic        [cpct_pkg::IDX_W-1:0] last_idx;
  logic signed [cpct_pkg::CMP_W-1:0] val_ext;
  logic signed [cpct_pkg::CMP_W-1:0] top_ext;
  logic        [7:0]                 int_part;
  logic        [7:0]                 rounded;

  always_comb begin
    last_idx = cpct_pkg::IDX_W'(count_i - cpct_pkg::CNT_W'(1));
    val_ext  = cpct_pkg::CMP_W'(class_value_i);
    top_ext  = $signed({1'b0, cpct_pkg::VAL_W'({last_idx, 8'h00})});
    int_part = class_value_i[15:8];
    // exact half rounds down
    rounded  = int_part + 8'((class_value_i[7:0] > cpct_pkg::HALF_Q8) ? 1 : 0);
    priority if (val_ext > top_ext) begin
      idx_o = last_idx;
    end else if (class_value_i[cpct_pkg::VAL_W-1]) begin
      idx_o = '0;
    end else begin
      idx_o = rounded[cpct_pkg::IDX_W-1:0];
    end
  end

endmodule

### rtl/color_palette_class_table_core.sv
// color palette class table
// keeps bgr colors in order of first appearance and maps colors to class
// indexes and back.
// input stream: tuser[0] action (0 classify, 1 render); tdata blue[7:0],
// green[15:8], red[23:16], signed q8.8 class_value[39:24].
// output stream: tdata class_index[7:0], out_blue[15:8], out_green[23:16],
// out_red[31:24]; tuser new_entry[0], table_full[1], table_empty[2].
// one result transaction per input transaction.
// classify walks the stored entries through one compare unit at one entry
// per cycle behind the registered ram read; a hit ends the walk at that
// entry, a miss walks all stored entries first. render clamps and rounds
// at acceptance, then reads the ram; on an empty table it skips the read.
// s_axis_tready is high only while no transaction is in work.
// the finished result sits in an output register, so the next transaction
// is taken while it waits; a further result waits in the core until the
// receiver takes the earlier one.
// reset empties the table (entry count zero); ram contents are not cleared
// and need no clearing pass, since only written entries are read.
module color_palette_class_table_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // blue, green, red, class_value
  input  logic [0:0]  s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // class_index, out_blue, out_green, out_red
  output logic [2:0]  m_axis_tuser   // new_entry, table_full, table_empty
);

`include "color_palette_class_table_core_defines.svh"

  localparam int IdxW = cpct_pkg::IDX_W;
  localparam int CntW = cpct_pkg::CNT_W;
  localparam int ColW = cpct_pkg::COLOR_W;

  cpct_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  rd_ptr_q, rd_ptr_d;     // next entry to read
  logic [IdxW-1:0]  cmp_ptr_q, cmp_ptr_d;   // entry now at the ram output
  logic             cmp_vld_q, cmp_vld_d;
  logic             out_vld_q, out_vld_d;

  // payload registers
  logic [ColW-1:0]  key_q, key_d;
  logic [IdxW-1:0]  ridx_q, ridx_d;
  logic [IdxW-1:0]  res_idx_q, res_idx_d;
  logic [ColW-1:0]  res_col_q, res_col_d;
  cpct_pkg::flags_t res_flg_q, res_flg_d;
  logic [31:0]      out_data_q, out_data_d;
  logic [2:0]       out_user_q, out_user_d;

  // ram ports
  logic             ram_we, ram_re;
  logic [IdxW-1:0]  ram_waddr, ram_raddr;
  logic [ColW-1:0]  ram_rdata;

  logic [IdxW-1:0]  render_idx;
  logic             s_hs;
  logic             out_free;
  logic             hit;

  assign s_hs     = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_vld_q || m_axis_tready;
  // the shared compare unit: stored entry against the key
  assign hit      = cmp_vld_q && (ram_rdata == key_q);

  cpct_idx u_idx (
    .class_value_i (s_axis_tdata[39:24]),
    .count_i       (count_q),
    .idx_o         (render_idx)
  );

  cpct_ram #(
    .Width (ColW),
    .Depth (cpct_pkg::PALETTE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (key_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    rd_ptr_d   = rd_ptr_q;
    cmp_ptr_d  = cmp_ptr_q;
    cmp_vld_d  = cmp_vld_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    key_d      = key_q;
    ridx_d     = ridx_q;
    res_idx_d  = res_idx_q;
    res_col_d  = res_col_q;
    res_flg_d  = res_flg_q;
    out_data_d = out_data_q;
    out_user_d = out_user_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = count_q[IdxW-1:0];
    ram_raddr  = (state_q == cpct_pkg::ST_SEARCH) ? rd_ptr_q[IdxW-1:0] : ridx_q;
    s_axis_tready = (state_q == cpct_pkg::ST_IDLE);

    unique case (state_q)
      cpct_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          key_d     = s_axis_tdata[ColW-1:0];
          res_idx_d = '0;
          res_col_d = '0;
          res_flg_d = '0;
          if (cpct_pkg::action_e'(s_axis_tuser[0]) == cpct_pkg::ACT_CLASSIFY) begin
            rd_ptr_d  = '0;
            cmp_vld_d = 1'b0;
            state_d   = cpct_pkg::ST_SEARCH;
          end else if (count_q == '0) begin
            res_flg_d.empty = 1'b1;
            state_d         = cpct_pkg::ST_FINISH;
          end else begin
            ridx_d  = render_idx;
            state_d = cpct_pkg::ST_RD;
          end
        end
      end
      cpct_pkg::ST_SEARCH: begin
        priority if (hit) begin
          res_idx_d = cmp_ptr_q;
          state_d   = cpct_pkg::ST_FINISH;
        end else if (rd_ptr_q < count_q) begin
          // keep one read in flight ahead of the compare
          ram_re    = 1'b1;
          rd_ptr_d  = rd_ptr_q + CntW'(1);
          cmp_ptr_d = rd_ptr_q[IdxW-1:0];
          cmp_vld_d = 1'b1;
        end else begin
          // miss: append if there is room
          cmp_vld_d = 1'b0;
          if (count_q < CntW'(cpct_pkg::PALETTE_DEPTH)) begin
            ram_we          = 1'b1;
            res_idx_d       = count_q[IdxW-1:0];
            res_flg_d.fresh = 1'b1;
            count_d         = count_q + CntW'(1);
          end else begin
            res_flg_d.full = 1'b1;
          end
          state_d = cpct_pkg::ST_FINISH;
        end
      end
      cpct_pkg::ST_RD: begin
        ram_re  = 1'b1;
        state_d = cpct_pkg::ST_RDATA;
      end
      cpct_pkg::ST_RDATA: begin
        res_idx_d = ridx_q;
        res_col_d = ram_rdata;
        state_d   = cpct_pkg::ST_FINISH;
      end
      cpct_pkg::ST_FINISH: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_data_d = {res_col_q[23:16], res_col_q[15:8], res_col_q[7:0], 8'(res_idx_q)};
          out_user_d = res_flg_q;
          state_d    = cpct_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cpct_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cpct_pkg::ST_IDLE;
      count_q   <= '0;
      rd_ptr_q  <= '0;
      cmp_ptr_q <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rd_ptr_q  <= rd_ptr_d;
      cmp_ptr_q <= cmp_ptr_d;
      cmp_vld_q <= cmp_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    ridx_q     <= ridx_d;
    res_idx_q  <= res_idx_d;
    res_col_q  <= res_col_d;
    res_flg_q  <= res_flg_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // table never grows past its depth
  `CPCT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CntW'(cpct_pkg::PALETTE_DEPTH))
  // an append only happens with a free entry
  `CPCT_ASSERT_NOW(a_write_room, ram_we, count_q < CntW'(cpct_pkg::PALETTE_DEPTH))
  // at most one result flag is raised
  `CPCT_ASSERT_NOW(a_flags_onehot, m_axis_tvalid, $onehot0(m_axis_tuser))
  // an accepted transaction closes the input until it is done
  `CPCT_ASSERT_NEXT(a_busy_after_accept, s_hs, !s_axis_tready)

endmodule
